>>> rtl/lqe_pkg.sv
package lqe_pkg;

    localparam int unsigned ValW    = 31;
    localparam int unsigned SumW    = 32;
    localparam int unsigned DiscW   = 68;
    localparam int unsigned RootW   = DiscW / 2;
    localparam int unsigned RemW    = RootW + 4;
    localparam int unsigned PairsPerStage = 2;
    localparam int unsigned SqrtStages    = RootW / PairsPerStage;

    localparam logic [ValW-1:0] OneQ16 = ValW'(65536);

    localparam logic [1:0] RegHalfSat = 2'd0;
    localparam logic [1:0] RegMaxCap  = 2'd1;

    // values that ride along with the square root
    typedef struct packed {
        logic [SumW-1:0] m;
        logic            b_neg;
        logic [SumW-1:0] b_mag;
    } t_side;

endpackage

>>> rtl/lqe_front.sv
module lqe_front
    import lqe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ValW-1:0]   i_sorbed_in,
    input  logic [ValW-1:0]   i_dissolved_in,
    input  logic [ValW-1:0]   i_k,
    input  logic [ValW-1:0]   i_q,
    output logic              o_valid,
    output logic [DiscW-1:0]  o_disc,
    output t_side             o_side
);

    logic [2:0]             r_vld;
    t_side                  r_s1, r_s2, r_s3;
    logic [ValW-1:0]        r_k1;
    logic [2*SumW-1:0]      r_sq2;
    logic [SumW+ValW-1:0]   r_mk2;
    logic [DiscW-1:0]       r_disc3;
    logic [SumW-1:0]        n_m, n_qk;

    assign n_m  = SumW'(i_sorbed_in) + SumW'(i_dissolved_in);
    assign n_qk = SumW'(i_k) + SumW'(i_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: total and linear coefficient magnitude
            r_s1.m     <= n_m;
            r_s1.b_neg <= n_m > n_qk;
            r_s1.b_mag <= (n_m > n_qk) ? (n_m - n_qk) : (n_qk - n_m);
            r_k1       <= i_k;
            // stage 2: products
            r_s2  <= r_s1;
            r_sq2 <= r_s1.b_mag * r_s1.b_mag;
            r_mk2 <= r_s1.m * r_k1;
            // stage 3: discriminant
            r_s3    <= r_s2;
            r_disc3 <= DiscW'(r_sq2) + DiscW'({r_mk2, 2'b00});
        end
    end

    assign o_valid = r_vld[2];
    assign o_disc  = r_disc3;
    assign o_side  = r_s3;

endmodule

>>> rtl/lqe_sqrt.sv
module lqe_sqrt
    import lqe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DiscW-1:0]  i_disc,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [RootW-1:0]  o_root,
    output t_side             o_side
);

    logic [SqrtStages-1:0]  r_vld;
    logic [RemW-1:0]        r_rem  [SqrtStages];
    logic [RootW-1:0]       r_root [SqrtStages];
    logic [DiscW-1:0]       r_d    [SqrtStages];
    t_side                  r_side [SqrtStages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SqrtStages-2:0], i_valid};
        end
    end

    for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
        logic [RemW-1:0]  w_rem;
        logic [RootW-1:0] w_root;
        logic [DiscW-1:0] w_d;
        t_side            w_side;
        logic [RemW-1:0]  n_rem;
        logic [RootW-1:0] n_root;
        logic [DiscW-1:0] n_d;

        if (g == 0) begin : g_head
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_d    = i_disc;
            assign w_side = i_side;
        end else begin : g_tail
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_d    = r_d[g-1];
            assign w_side = r_side[g-1];
        end

        always_comb begin
            logic [RemW-1:0] trial;
            n_rem  = w_rem;
            n_root = w_root;
            n_d    = w_d;
            // one result bit per pair of discriminant bits, msb first
            for (int p = 0; p < PairsPerStage; p++) begin
                n_rem = {n_rem[RemW-3:0], n_d[DiscW-1 -: 2]};
                n_d   = {n_d[DiscW-3:0], 2'b00};
                trial = RemW'({n_root, 2'b01});
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[RootW-2:0], 1'b1};
                end else begin
                    n_root = {n_root[RootW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_d[g]    <= n_d;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[SqrtStages-1];
    assign o_root  = r_root[SqrtStages-1];
    assign o_side  = r_side[SqrtStages-1];

endmodule

>>> rtl/lqe_back.sv
module lqe_back
    import lqe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RootW-1:0]  i_root,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [SumW-1:0]   o_sorbed,
    output logic [SumW-1:0]   o_dissolved
);

    logic            r_vld;
    logic [SumW-1:0] r_sorbed, r_dissolved;
    logic [RootW:0]  n_sum;
    logic [RootW:0]  n_root;
    logic [SumW-1:0] n_clamp;

    always_comb begin
        if (i_side.b_neg) begin
            n_sum  = {1'b0, i_root} + (RootW+1)'(i_side.b_mag);
        end else if ({1'b0, i_root} >= (RootW+1)'(i_side.b_mag)) begin
            n_sum  = {1'b0, i_root} - (RootW+1)'(i_side.b_mag);
        end else begin
            n_sum  = '0;
        end
        n_root  = n_sum >> 1;
        n_clamp = (n_root > (RootW+1)'(i_side.m)) ? i_side.m : n_root[SumW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dissolved <= n_clamp;
            r_sorbed    <= i_side.m - n_clamp;
        end
    end

    assign o_valid     = r_vld;
    assign o_sorbed    = r_sorbed;
    assign o_dissolved = r_dissolved;

endmodule

>>> rtl/langmuir_equilibrium_split.sv
// Langmuir equilibrium split.
// Input channel (i_valid / o_ready) carries one transaction: sorbed and
// dissolved amounts, unsigned Q15.16. The block forms the total M, solves the
// Langmuir quadratic for the dissolved equilibrium amount and returns it with
// the sorbed remainder M - B on the output channel (o_valid / i_ready), Q16.16.
// Configuration: write half saturation K (index 0) or capacity qmax
// (index 1) with i_cfg_we; other indices are ignored. Write only while idle.
// The pipeline has three front stages (total, products, discriminant),
// 17 square root stages retiring two root bits each, and one output register.
// Throughput is one transaction per cycle while the receiver does not stall the output.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken. When the receiver stalls with a result
// waiting, every stage holds, and o_ready drops until the result is taken;
// empty slots ahead of it do not fill while the stall lasts.
// Reset (synchronous, active low) clears all valid bits and sets K and qmax
// to 1.0; no result is pending afterwards.
module langmuir_equilibrium_split
    import lqe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [ValW-1:0]  i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ValW-1:0]  i_sorbed_in,
    input  logic [ValW-1:0]  i_dissolved_in,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SumW-1:0]  o_sorbed_out,
    output logic [SumW-1:0]  o_dissolved_out
);

    logic [ValW-1:0]  r_k, r_q;
    logic             w_en;
    logic             w_fr_vld, w_sq_vld;
    logic [DiscW-1:0] w_disc;
    logic [RootW-1:0] w_root;
    t_side            w_fr_side, w_sq_side;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= OneQ16;
            r_q <= OneQ16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegHalfSat: r_k <= i_cfg_data;
                RegMaxCap:  r_q <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // advance unless a finished result is stuck at the output
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    lqe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_sorbed_in    (i_sorbed_in),
        .i_dissolved_in (i_dissolved_in),
        .i_k            (r_k),
        .i_q            (r_q),
        .o_valid        (w_fr_vld),
        .o_disc         (w_disc),
        .o_side         (w_fr_side)
    );

    lqe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_vld),
        .i_disc  (w_disc),
        .i_side  (w_fr_side),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    lqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_sq_vld),
        .i_root      (w_root),
        .i_side      (w_sq_side),
        .o_valid     (o_valid),
        .o_sorbed    (o_sorbed_out),
        .o_dissolved (o_dissolved_out)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_sorbed_out} + {1'b0, o_dissolved_out}) < 33'h1_0000_0000)
        else $error("split exceeds total range");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_dissolved_out) && $stable(o_sorbed_out))
        else $error("stalled result changed");

endmodule

>>> bench/langmuir_equilibrium_split_tb.sv
`timescale 1ns / 100ps

module langmuir_equilibrium_split_tb;
    import lqe_pkg::*;

    localparam int unsigned RandomItems = 1650;
    localparam int unsigned Latency     = 21;
    localparam int unsigned CycleLimit  = 400000;

    typedef struct {
        logic [ValW-1:0] sorbed;
        logic [ValW-1:0] dissolved;
        logic            typed;     // expected result given in the row
        logic [SumW-1:0] exp_sorbed;
        logic [SumW-1:0] exp_dissolved;
    } t_row;

    typedef struct {
        logic [SumW-1:0] sorbed;
        logic [SumW-1:0] dissolved;
    } t_split;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_idx;
    logic [ValW-1:0] i_cfg_data;
    logic            i_valid;
    logic            o_ready;
    logic [ValW-1:0] i_sorbed_in;
    logic [ValW-1:0] i_dissolved_in;
    logic            o_valid;
    logic            i_ready;
    logic [SumW-1:0] o_sorbed_out;
    logic [SumW-1:0] o_dissolved_out;

    // predictor copy of the two registers
    logic [ValW-1:0] half_sat_q;
    logic [ValW-1:0] max_cap_q;

    t_split      split_queue[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned cycle_count;
    bit          rx_hold;     // long receiver hold-off
    bit          rx_no_idle;  // stretch with no receiver idling

    langmuir_equilibrium_split DUT (.*);

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Compute the equilibrium split for one transaction with exact wide math.
    function automatic t_split equilibrium_split(logic [ValW-1:0] a, logic [ValW-1:0] b);
        logic [33:0]  m, qk, b_mag;
        logic         b_neg;
        logic [127:0] disc, trial;
        logic [63:0]  root_s, t, root;
        t_split       res;
        m      = 34'(a) + 34'(b);
        qk     = 34'(max_cap_q) + 34'(half_sat_q);
        b_neg  = m > qk;
        b_mag  = b_neg ? m - qk : qk - m;
        disc   = 128'(b_mag) * 128'(b_mag) + 128'(m) * 128'(half_sat_q) * 128'd4;
        root_s = '0;
        for (int bit_i = 34; bit_i >= 0; bit_i--) begin
            t     = root_s | (64'd1 << bit_i);
            trial = 128'(t) * 128'(t);
            if (trial <= disc) root_s = t;
        end
        if (b_neg) root = (root_s + 64'(b_mag)) >> 1;
        else root = (root_s >= 64'(b_mag)) ? (root_s - 64'(b_mag)) >> 1 : 64'd0;
        if (root > 64'(m)) root = 64'(m);
        res.sorbed    = SumW'(64'(m) - root);
        res.dissolved = SumW'(root);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [SumW-1:0] got, logic [SumW-1:0] want);
        $display("MISMATCH %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
        mismatches++;
    endtask

    // Check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (split_queue.size() == 0) begin
                report_mismatch("unexpected result", o_dissolved_out, '0);
            end else begin
                t_split want;
                want = split_queue.pop_front();
                if (o_sorbed_out !== want.sorbed)
                    report_mismatch("sorbed_out", o_sorbed_out, want.sorbed);
                if (o_dissolved_out !== want.dissolved)
                    report_mismatch("dissolved_out", o_dissolved_out, want.dissolved);
            end
        end
    end

    // Receiver: idles with a chance of 21 in a hundred, except in no-idle stretches or holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (rx_hold) i_ready <= 1'b0;
        else if (rx_no_idle) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 21);
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [ValW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == RegHalfSat) half_sat_q = val;
        else if (idx == RegMaxCap) max_cap_q = val;
    endtask

    // Offer one transaction; hold it until accepted. Expectation is queued at acceptance.
    task automatic send_item(logic [ValW-1:0] a, logic [ValW-1:0] b, bit may_idle,
                             bit typed, t_split typed_exp);
        t_split exp_res;
        while (may_idle && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        exp_res = typed ? typed_exp : equilibrium_split(a, b);
        i_valid        <= 1'b1;
        i_sorbed_in    <= a;
        i_dissolved_in <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        split_queue.push_back(exp_res);
    endtask

    // Drain: wait for every expected result, then for the pipeline depth.
    task automatic drain();
        i_valid <= 1'b0;
        while (split_queue.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    // Random operand: mostly small totals near the constants, sometimes full range.
    function automatic logic [ValW-1:0] rand_amount();
        case ($urandom_range(3))
            0: rand_amount = ValW'($urandom);
            1: rand_amount = ValW'($urandom_range(32'h0004_0000));
            2: rand_amount = ValW'($urandom_range(255));
            default: rand_amount = ValW'($urandom) >> $urandom_range(30);
        endcase
    endfunction

    t_row directed[$];
    t_split none;

    initial begin
        logic [ValW-1:0] max_v;
        max_v = '1;
        none  = '{default: '0};
        i_rst_n = 1'b0; i_valid = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0;
        i_cfg_data = '0; i_sorbed_in = '0; i_dissolved_in = '0; i_ready = 1'b0;
        rx_hold = 1'b0; rx_no_idle = 1'b0;
        mismatches = 0; results_seen = 0; cycle_count = 0;
        half_sat_q = OneQ16; max_cap_q = OneQ16;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; zero total has typed zeros, others go through the predictor.
        directed = '{
            '{'0, '0, 1'b1, '0, '0},
            '{max_v, '0, 1'b0, '0, '0},
            '{'0, max_v, 1'b0, '0, '0},
            '{max_v, max_v, 1'b0, '0, '0},
            '{OneQ16, OneQ16, 1'b0, '0, '0},
            '{31'h0000_0001, '0, 1'b0, '0, '0},
            '{'0, 31'h0000_0001, 1'b0, '0, '0},
            '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0, '0},
            '{31'h0001_8000, 31'h0000_8000, 1'b0, '0, '0}
        };
        foreach (directed[i])
            send_item(directed[i].sorbed, directed[i].dissolved, 1'b0, directed[i].typed,
                      '{directed[i].exp_sorbed, directed[i].exp_dissolved});
        drain();

        // Both coefficients zero: all of the total stays dissolved.
        write_reg(RegHalfSat, '0);
        write_reg(RegMaxCap, '0);
        send_item('0, '0, 1'b0, 1'b1, none);
        send_item(31'h0000_0003, 31'h0000_0004, 1'b0, 1'b1, '{32'd0, 32'd7});
        send_item(max_v, max_v, 1'b0, 1'b1, '{32'd0, 32'hFFFF_FFFE});
        send_item(31'h1234_5678, '0, 1'b0, 1'b0, none);
        drain();

        // Unknown register indexes leave K and qmax alone.
        write_reg(2'd2, max_v);
        write_reg(2'd3, max_v);
        send_item(OneQ16, OneQ16, 1'b0, 1'b0, none);
        drain();

        // Random phases, each under a new register setting, extremes included.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(RegHalfSat, max_v); write_reg(RegMaxCap, max_v); end
                1: begin write_reg(RegHalfSat, max_v); write_reg(RegMaxCap, '0); end
                2: begin write_reg(RegHalfSat, '0); write_reg(RegMaxCap, max_v); end
                3: begin write_reg(RegHalfSat, 31'h1); write_reg(RegMaxCap, 31'h1); end
                default: begin
                    write_reg(RegHalfSat, rand_amount());
                    write_reg(RegMaxCap, rand_amount());
                end
            endcase
            rx_no_idle = (phase == 5);
            for (int n = 0; n < RandomItems / 8; n++) begin
                if (phase == 3 && n == 50) begin
                    // Hold off the receiver while the sender keeps offering items.
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (120) @(posedge i_clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                if (phase == 4 && n == 100) begin
                    // Pause the sender until every expected result has come.
                    i_valid <= 1'b0;
                    while (split_queue.size() != 0) @(posedge i_clk);
                end
                send_item(rand_amount(), rand_amount(), !rx_no_idle, 1'b0, none);
            end
            drain();
            rx_no_idle = 1'b0;
        end

        $display("Covered zero totals, field extremes, zero and full-scale coefficients,");
        $display("%0d results checked over 8 random settings with stalls and hold-offs.",
                 results_seen);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> langmuir_equilibrium_split.f
rtl/lqe_pkg.sv
rtl/lqe_front.sv
rtl/lqe_sqrt.sv
rtl/lqe_back.sv
rtl/langmuir_equilibrium_split.sv
bench/langmuir_equilibrium_split_tb.sv
